@@ hw/rtl/qm_pkg.sv @@
// Package with sizes, term types and the cover test of the logic minimizer.
package qm_pkg;

	// Number of input variables and capacities of the stores.
	localparam int VARS      = 6;
	localparam int MT_DEPTH  = 64;
	localparam int MT_AW     = $clog2(MT_DEPTH);
	localparam int MT_CW     = MT_AW + 1;
	localparam int LVL_DEPTH = 256;
	localparam int LVL_AW    = $clog2(LVL_DEPTH);
	localparam int LVL_CW    = LVL_AW + 1;
	localparam int PR_DEPTH  = 1024;
	localparam int PR_AW     = $clog2(PR_DEPTH);
	localparam int PR_CW     = PR_AW + 1;
	localparam int IDX_W     = PR_CW;

	// One term of a merge level: merged flag, don't-care mask and literal bits.
	typedef struct packed {
		logic            merged;
		logic [VARS-1:0] mask;
		logic [VARS-1:0] bits;
	} lvl_term_t;

	// One prime implicant: selected flag, don't-care mask and literal bits.
	typedef struct packed {
		logic            sel;
		logic [VARS-1:0] mask;
		logic [VARS-1:0] bits;
	} pr_term_t;

	// True when the term given by mask and bits covers minterm v.
	function automatic logic covers(logic [VARS-1:0] mask, logic [VARS-1:0] bits,
			logic [VARS-1:0] v);
		return ((v ^ bits) & ~mask) == '0;
	endfunction

endpackage

@@ hw/rtl/qm_ram.sv @@
// Generic memory with one write port and one registered read port.
module qm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/logic_minimizer_qm.sv @@
// Top level of the two-level logic minimizer (prime implicants and cover).
//
// Usage: minterms enter one transaction per cycle while busy is low; a
// transaction is taken at a clock edge with start high and busy low. present
// marks a valid minterm; an item with last high starts minimization, after
// which busy stays high until the job's results have been sent. Minterms
// beyond 64 are dropped and the job's overflow flag is raised.
// Results are shown for one cycle each, marked by strobe, in prime order;
// final_res marks the last one. An empty function gives one result with
// empty_res high. The receiver cannot stall the output.
// The job then walks the stores in sequence through registered memory reads:
// each term pair in each merge level is compared, each merged term is
// searched for linearly in the next level and each new prime in the prime
// list, and each prime and minterm pair is tested in each cover pass.
// Reset clears the sequencer, the minterm count and the overflow flag; the
// memories need no clearing pass.
module logic_minimizer_qm (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [qm_pkg::VARS-1:0] minterm,
	input  logic                    present,
	input  logic                    last,
	output logic                    strobe,
	output logic [qm_pkg::VARS-1:0] implicant_bits,
	output logic [qm_pkg::VARS-1:0] implicant_mask,
	output logic                    empty_res,
	output logic                    overflow,
	output logic                    final_res
);

	localparam int SW = 5;
	localparam int IW = qm_pkg::IDX_W;

	localparam logic [SW-1:0] S_LOAD     = 5'd0;
	localparam logic [SW-1:0] S_INIT_RD  = 5'd1;
	localparam logic [SW-1:0] S_INIT_WR  = 5'd2;
	localparam logic [SW-1:0] S_LV_START = 5'd3;
	localparam logic [SW-1:0] S_I_RD     = 5'd4;
	localparam logic [SW-1:0] S_I_DT     = 5'd5;
	localparam logic [SW-1:0] S_J_RD     = 5'd6;
	localparam logic [SW-1:0] S_J_DT     = 5'd7;
	localparam logic [SW-1:0] S_N_RD     = 5'd8;
	localparam logic [SW-1:0] S_N_DT     = 5'd9;
	localparam logic [SW-1:0] S_P_RD     = 5'd10;
	localparam logic [SW-1:0] S_P_DT     = 5'd11;
	localparam logic [SW-1:0] S_PS_RD    = 5'd12;
	localparam logic [SW-1:0] S_PS_DT    = 5'd13;
	localparam logic [SW-1:0] S_CLR      = 5'd14;
	localparam logic [SW-1:0] S_E_RD     = 5'd15;
	localparam logic [SW-1:0] S_E_DT     = 5'd16;
	localparam logic [SW-1:0] S_EP_RD    = 5'd17;
	localparam logic [SW-1:0] S_EP_DT    = 5'd18;
	localparam logic [SW-1:0] S_M_RD     = 5'd19;
	localparam logic [SW-1:0] S_M_DT     = 5'd20;
	localparam logic [SW-1:0] S_G_CHK    = 5'd21;
	localparam logic [SW-1:0] S_G_CDT    = 5'd22;
	localparam logic [SW-1:0] S_G_PRD    = 5'd23;
	localparam logic [SW-1:0] S_G_PDT    = 5'd24;
	localparam logic [SW-1:0] S_G_MRD    = 5'd25;
	localparam logic [SW-1:0] S_G_MDT    = 5'd26;
	localparam logic [SW-1:0] S_O_RD     = 5'd27;
	localparam logic [SW-1:0] S_O_DT     = 5'd28;
	localparam logic [SW-1:0] S_O_END    = 5'd29;

	localparam logic RET_ESS = 1'b0;
	localparam logic RET_GRD = 1'b1;

	logic [SW-1:0]                state_q;
	logic [qm_pkg::MT_CW-1:0]     cnt_q;
	logic                         ovf_q;
	logic                         cur_sel_q;
	logic [qm_pkg::LVL_CW-1:0]    ncur_q;
	logic [qm_pkg::LVL_CW-1:0]    nnxt_q;
	logic [qm_pkg::PR_CW-1:0]     pc_q;
	logic [IW-1:0]                i_q;
	logic [IW-1:0]                j_q;
	logic [IW-1:0]                k_q;
	qm_pkg::lvl_term_t            ti_q;
	logic [qm_pkg::VARS-1:0]      nb_q;
	logic [qm_pkg::VARS-1:0]      nm_q;
	logic [qm_pkg::VARS-1:0]      v_q;
	logic [1:0]                   hits_q;
	logic [qm_pkg::PR_AW-1:0]     which_q;
	logic [qm_pkg::PR_AW-1:0]     best_q;
	logic [qm_pkg::MT_CW-1:0]     n_q;
	logic [qm_pkg::MT_CW-1:0]     best_n_q;
	logic                         found_q;
	logic                         ret_q;
	qm_pkg::pr_term_t             pt_q;
	qm_pkg::pr_term_t             bt_q;
	qm_pkg::pr_term_t             ct_q;
	qm_pkg::pr_term_t             pend_q;
	logic                         pend_v_q;
	logic                         strobe_q;
	logic [qm_pkg::VARS-1:0]      obits_q;
	logic [qm_pkg::VARS-1:0]      omask_q;
	logic                         oempty_q;
	logic                         oovf_q;
	logic                         ofinal_q;

	// Memory ports.
	logic                         mt_we;
	logic [qm_pkg::MT_AW-1:0]     mt_waddr;
	logic [qm_pkg::VARS-1:0]      mt_wdata;
	logic [qm_pkg::MT_AW-1:0]     mt_raddr;
	logic [qm_pkg::VARS-1:0]      mt_rd;
	logic                         cur_we;
	logic [qm_pkg::LVL_AW-1:0]    cur_waddr;
	qm_pkg::lvl_term_t            cur_wdata;
	logic [qm_pkg::LVL_AW-1:0]    cur_raddr;
	qm_pkg::lvl_term_t            cur_rd;
	logic                         nxt_we;
	logic [qm_pkg::LVL_AW-1:0]    nxt_waddr;
	qm_pkg::lvl_term_t            nxt_wdata;
	logic [qm_pkg::LVL_AW-1:0]    nxt_raddr;
	qm_pkg::lvl_term_t            nxt_rd;
	logic                         l0_we;
	logic [qm_pkg::LVL_AW-1:0]    l0_waddr;
	qm_pkg::lvl_term_t            l0_wdata;
	logic [qm_pkg::LVL_AW-1:0]    l0_raddr;
	qm_pkg::lvl_term_t            l0_rd;
	logic                         l1_we;
	logic [qm_pkg::LVL_AW-1:0]    l1_waddr;
	qm_pkg::lvl_term_t            l1_wdata;
	logic [qm_pkg::LVL_AW-1:0]    l1_raddr;
	qm_pkg::lvl_term_t            l1_rd;
	logic                         pr_we;
	logic [qm_pkg::PR_AW-1:0]     pr_waddr;
	qm_pkg::pr_term_t             pr_wdata;
	logic [qm_pkg::PR_AW-1:0]     pr_raddr;
	qm_pkg::pr_term_t             pr_rd;
	logic                         cov_we;
	logic [qm_pkg::MT_AW-1:0]     cov_waddr;
	logic                         cov_wdata;
	logic [qm_pkg::MT_AW-1:0]     cov_raddr;
	logic                         cov_rd;

	// Loop bounds and the shared compare results.
	logic                         accept;
	logic                         mt_room;
	logic                         i_ge_cnt;
	logic                         j_ge_cnt;
	logic                         k_ge_cnt;
	logic                         i_ge_ncur;
	logic                         j_ge_ncur;
	logic                         k_ge_nnxt;
	logic                         i_ge_pc;
	logic                         j_ge_pc;
	logic                         k_ge_pc;
	logic                         nxt_room;
	logic                         pr_room;
	logic [qm_pkg::VARS-1:0]      diff;
	logic                         mrg;
	logic                         nxt_eq;
	logic                         pr_eq;

	assign accept    = start && !busy;
	assign mt_room   = cnt_q != qm_pkg::MT_CW'(qm_pkg::MT_DEPTH);
	assign i_ge_cnt  = i_q >= IW'(cnt_q);
	assign j_ge_cnt  = j_q >= IW'(cnt_q);
	assign k_ge_cnt  = k_q >= IW'(cnt_q);
	assign i_ge_ncur = i_q >= IW'(ncur_q);
	assign j_ge_ncur = j_q >= IW'(ncur_q);
	assign k_ge_nnxt = k_q >= IW'(nnxt_q);
	assign i_ge_pc   = i_q >= IW'(pc_q);
	assign j_ge_pc   = j_q >= IW'(pc_q);
	assign k_ge_pc   = k_q >= IW'(pc_q);
	assign nxt_room  = nnxt_q != qm_pkg::LVL_CW'(qm_pkg::LVL_DEPTH);
	assign pr_room   = pc_q != qm_pkg::PR_CW'(qm_pkg::PR_DEPTH);
	assign diff      = ti_q.bits ^ cur_rd.bits;
	assign mrg       = (ti_q.mask == cur_rd.mask) && (diff != '0) &&
		((diff & (diff - 1'b1)) == '0);
	assign nxt_eq    = (nxt_rd.bits == nb_q) && (nxt_rd.mask == nm_q);
	assign pr_eq     = (pr_rd.bits == ti_q.bits) && (pr_rd.mask == ti_q.mask);

	// Memory port control, decoded from the sequencer state.
	always_comb begin
		mt_we     = 1'b0;
		mt_waddr  = cnt_q[qm_pkg::MT_AW-1:0];
		mt_wdata  = minterm;
		mt_raddr  = '0;
		cur_we    = 1'b0;
		cur_waddr = i_q[qm_pkg::LVL_AW-1:0];
		cur_wdata = ti_q;
		cur_raddr = '0;
		nxt_we    = 1'b0;
		nxt_waddr = nnxt_q[qm_pkg::LVL_AW-1:0];
		nxt_wdata = '{merged: 1'b0, mask: nm_q, bits: nb_q};
		nxt_raddr = k_q[qm_pkg::LVL_AW-1:0];
		pr_we     = 1'b0;
		pr_waddr  = pc_q[qm_pkg::PR_AW-1:0];
		pr_wdata  = '{sel: 1'b0, mask: ti_q.mask, bits: ti_q.bits};
		pr_raddr  = '0;
		cov_we    = 1'b0;
		cov_waddr = k_q[qm_pkg::MT_AW-1:0];
		cov_wdata = 1'b0;
		cov_raddr = '0;
		unique case (state_q)
			S_LOAD: begin
				mt_we = accept && present && mt_room;
			end
			S_INIT_RD, S_E_RD: begin
				mt_raddr = i_q[qm_pkg::MT_AW-1:0];
			end
			S_INIT_WR: begin
				cur_we    = 1'b1;
				cur_wdata = '{merged: 1'b0, mask: '0, bits: mt_rd};
			end
			S_I_RD, S_P_RD: begin
				cur_raddr = i_q[qm_pkg::LVL_AW-1:0];
			end
			S_J_RD: begin
				cur_we    = j_ge_ncur;
				cur_raddr = j_q[qm_pkg::LVL_AW-1:0];
			end
			S_J_DT: begin
				cur_we    = mrg;
				cur_waddr = j_q[qm_pkg::LVL_AW-1:0];
				cur_wdata = '{merged: 1'b1, mask: cur_rd.mask, bits: cur_rd.bits};
			end
			S_N_RD: begin
				nxt_we = k_ge_nnxt && nxt_room;
			end
			S_PS_RD: begin
				pr_we    = k_ge_pc && pr_room;
				pr_raddr = k_q[qm_pkg::PR_AW-1:0];
			end
			S_CLR: begin
				cov_we = !k_ge_cnt;
			end
			S_EP_RD: begin
				pr_we    = j_ge_pc && (hits_q == 2'd1);
				pr_waddr = which_q;
				pr_wdata = '{sel: 1'b1, mask: pt_q.mask, bits: pt_q.bits};
				pr_raddr = j_q[qm_pkg::PR_AW-1:0];
			end
			S_M_RD: begin
				mt_raddr = k_q[qm_pkg::MT_AW-1:0];
			end
			S_M_DT: begin
				cov_we    = qm_pkg::covers(pt_q.mask, pt_q.bits, mt_rd);
				cov_wdata = 1'b1;
			end
			S_G_CHK: begin
				cov_raddr = k_q[qm_pkg::MT_AW-1:0];
			end
			S_G_PRD: begin
				pr_we    = i_ge_pc && found_q;
				pr_waddr = best_q;
				pr_wdata = '{sel: 1'b1, mask: bt_q.mask, bits: bt_q.bits};
				pr_raddr = i_q[qm_pkg::PR_AW-1:0];
			end
			S_G_MRD: begin
				mt_raddr  = j_q[qm_pkg::MT_AW-1:0];
				cov_raddr = j_q[qm_pkg::MT_AW-1:0];
			end
			S_O_RD: begin
				pr_raddr = i_q[qm_pkg::PR_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// The two level tables swap roles as current and next level.
	always_comb begin
		l0_we    = cur_sel_q ? nxt_we    : cur_we;
		l0_waddr = cur_sel_q ? nxt_waddr : cur_waddr;
		l0_wdata = cur_sel_q ? nxt_wdata : cur_wdata;
		l0_raddr = cur_sel_q ? nxt_raddr : cur_raddr;
		l1_we    = cur_sel_q ? cur_we    : nxt_we;
		l1_waddr = cur_sel_q ? cur_waddr : nxt_waddr;
		l1_wdata = cur_sel_q ? cur_wdata : nxt_wdata;
		l1_raddr = cur_sel_q ? cur_raddr : nxt_raddr;
		cur_rd   = cur_sel_q ? l1_rd : l0_rd;
		nxt_rd   = cur_sel_q ? l0_rd : l1_rd;
	end

	qm_ram #(.WIDTH(qm_pkg::VARS), .DEPTH(qm_pkg::MT_DEPTH)) u_mt_ram (
		.clk(clk), .we(mt_we), .waddr(mt_waddr), .wdata(mt_wdata),
		.raddr(mt_raddr), .rdata(mt_rd)
	);

	qm_ram #(.WIDTH($bits(qm_pkg::lvl_term_t)), .DEPTH(qm_pkg::LVL_DEPTH)) u_lvl0_ram (
		.clk(clk), .we(l0_we), .waddr(l0_waddr), .wdata(l0_wdata),
		.raddr(l0_raddr), .rdata(l0_rd)
	);

	qm_ram #(.WIDTH($bits(qm_pkg::lvl_term_t)), .DEPTH(qm_pkg::LVL_DEPTH)) u_lvl1_ram (
		.clk(clk), .we(l1_we), .waddr(l1_waddr), .wdata(l1_wdata),
		.raddr(l1_raddr), .rdata(l1_rd)
	);

	qm_ram #(.WIDTH($bits(qm_pkg::pr_term_t)), .DEPTH(qm_pkg::PR_DEPTH)) u_pr_ram (
		.clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
		.raddr(pr_raddr), .rdata(pr_rd)
	);

	qm_ram #(.WIDTH(1), .DEPTH(qm_pkg::MT_DEPTH)) u_cov_ram (
		.clk(clk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
		.raddr(cov_raddr), .rdata(cov_rd)
	);

	// Sequencer: load, merge levels, harvest primes, cover, and emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			cur_sel_q <= 1'b0;
			ncur_q    <= '0;
			nnxt_q    <= '0;
			pc_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			ti_q      <= '0;
			nb_q      <= '0;
			nm_q      <= '0;
			v_q       <= '0;
			hits_q    <= '0;
			which_q   <= '0;
			best_q    <= '0;
			n_q       <= '0;
			best_n_q  <= '0;
			found_q   <= 1'b0;
			ret_q     <= RET_ESS;
			pt_q      <= '0;
			bt_q      <= '0;
			ct_q      <= '0;
			pend_q    <= '0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
			obits_q   <= '0;
			omask_q   <= '0;
			oempty_q  <= 1'b0;
			oovf_q    <= 1'b0;
			ofinal_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (present) begin
							if (mt_room) begin
								cnt_q <= cnt_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (last) begin
							i_q       <= '0;
							pc_q      <= '0;
							cur_sel_q <= 1'b0;
							state_q   <= S_INIT_RD;
						end
					end
				end
				S_INIT_RD: begin
					if (i_ge_cnt) begin
						ncur_q  <= qm_pkg::LVL_CW'(cnt_q);
						state_q <= S_LV_START;
					end else begin
						state_q <= S_INIT_WR;
					end
				end
				S_INIT_WR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_INIT_RD;
				end
				S_LV_START: begin
					if (ncur_q == '0) begin
						k_q     <= '0;
						state_q <= S_CLR;
					end else begin
						nnxt_q  <= '0;
						i_q     <= '0;
						state_q <= S_I_RD;
					end
				end
				S_I_RD: begin
					if (i_ge_ncur) begin
						i_q     <= '0;
						state_q <= S_P_RD;
					end else begin
						state_q <= S_I_DT;
					end
				end
				S_I_DT: begin
					ti_q    <= cur_rd;
					j_q     <= i_q + 1'b1;
					state_q <= S_J_RD;
				end
				S_J_RD: begin
					if (j_ge_ncur) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_I_RD;
					end else begin
						state_q <= S_J_DT;
					end
				end
				S_J_DT: begin
					if (mrg) begin
						ti_q.merged <= 1'b1;
						nb_q        <= ti_q.bits & cur_rd.bits;
						nm_q        <= ti_q.mask | diff;
						k_q         <= '0;
						state_q     <= S_N_RD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_J_RD;
					end
				end
				S_N_RD: begin
					if (k_ge_nnxt) begin
						if (nxt_room) begin
							nnxt_q <= nnxt_q + 1'b1;
						end
						j_q     <= j_q + 1'b1;
						state_q <= S_J_RD;
					end else begin
						state_q <= S_N_DT;
					end
				end
				S_N_DT: begin
					if (nxt_eq) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_J_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_N_RD;
					end
				end
				S_P_RD: begin
					if (i_ge_ncur) begin
						cur_sel_q <= ~cur_sel_q;
						ncur_q    <= nnxt_q;
						state_q   <= S_LV_START;
					end else begin
						state_q <= S_P_DT;
					end
				end
				S_P_DT: begin
					ti_q <= cur_rd;
					if (cur_rd.merged) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_P_RD;
					end else begin
						k_q     <= '0;
						state_q <= S_PS_RD;
					end
				end
				S_PS_RD: begin
					if (k_ge_pc) begin
						if (pr_room) begin
							pc_q <= pc_q + 1'b1;
						end
						i_q     <= i_q + 1'b1;
						state_q <= S_P_RD;
					end else begin
						state_q <= S_PS_DT;
					end
				end
				S_PS_DT: begin
					if (pr_eq) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_P_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_PS_RD;
					end
				end
				S_CLR: begin
					if (k_ge_cnt) begin
						i_q     <= '0;
						state_q <= S_E_RD;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_E_RD: begin
					if (i_ge_cnt) begin
						k_q     <= '0;
						state_q <= S_G_CHK;
					end else begin
						state_q <= S_E_DT;
					end
				end
				S_E_DT: begin
					v_q     <= mt_rd;
					j_q     <= '0;
					hits_q  <= '0;
					state_q <= S_EP_RD;
				end
				S_EP_RD: begin
					if (j_ge_pc) begin
						if (hits_q == 2'd1) begin
							ret_q   <= RET_ESS;
							k_q     <= '0;
							state_q <= S_M_RD;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_E_RD;
						end
					end else begin
						state_q <= S_EP_DT;
					end
				end
				S_EP_DT: begin
					if (qm_pkg::covers(pr_rd.mask, pr_rd.bits, v_q)) begin
						if (hits_q != 2'd2) begin
							hits_q <= hits_q + 1'b1;
						end
						which_q <= j_q[qm_pkg::PR_AW-1:0];
						pt_q    <= pr_rd;
					end
					j_q     <= j_q + 1'b1;
					state_q <= S_EP_RD;
				end
				S_M_RD: begin
					if (k_ge_cnt) begin
						if (ret_q == RET_ESS) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_E_RD;
						end else begin
							k_q     <= '0;
							state_q <= S_G_CHK;
						end
					end else begin
						state_q <= S_M_DT;
					end
				end
				S_M_DT: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_M_RD;
				end
				S_G_CHK: begin
					if (k_ge_cnt) begin
						i_q      <= '0;
						pend_v_q <= 1'b0;
						state_q  <= S_O_RD;
					end else begin
						state_q <= S_G_CDT;
					end
				end
				S_G_CDT: begin
					if (!cov_rd) begin
						i_q      <= '0;
						best_n_q <= '0;
						found_q  <= 1'b0;
						state_q  <= S_G_PRD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_G_CHK;
					end
				end
				S_G_PRD: begin
					if (i_ge_pc) begin
						if (found_q) begin
							pt_q    <= bt_q;
							ret_q   <= RET_GRD;
							k_q     <= '0;
							state_q <= S_M_RD;
						end else begin
							i_q      <= '0;
							pend_v_q <= 1'b0;
							state_q  <= S_O_RD;
						end
					end else begin
						state_q <= S_G_PDT;
					end
				end
				S_G_PDT: begin
					ct_q <= pr_rd;
					if (pr_rd.sel) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_G_PRD;
					end else begin
						n_q     <= '0;
						j_q     <= '0;
						state_q <= S_G_MRD;
					end
				end
				S_G_MRD: begin
					if (j_ge_cnt) begin
						if (n_q > best_n_q) begin
							best_n_q <= n_q;
							best_q   <= i_q[qm_pkg::PR_AW-1:0];
							bt_q     <= ct_q;
							found_q  <= 1'b1;
						end
						i_q     <= i_q + 1'b1;
						state_q <= S_G_PRD;
					end else begin
						state_q <= S_G_MDT;
					end
				end
				S_G_MDT: begin
					if (!cov_rd && qm_pkg::covers(ct_q.mask, ct_q.bits, mt_rd)) begin
						n_q <= n_q + 1'b1;
					end
					j_q     <= j_q + 1'b1;
					state_q <= S_G_MRD;
				end
				S_O_RD: begin
					if (i_ge_pc) begin
						state_q <= S_O_END;
					end else begin
						state_q <= S_O_DT;
					end
				end
				S_O_DT: begin
					// Hold one selected prime back so the last one can carry final_res.
					if (pr_rd.sel) begin
						if (pend_v_q) begin
							strobe_q <= 1'b1;
							obits_q  <= pend_q.bits;
							omask_q  <= pend_q.mask;
							oempty_q <= 1'b0;
							oovf_q   <= ovf_q;
							ofinal_q <= 1'b0;
						end
						pend_q   <= pr_rd;
						pend_v_q <= 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_O_RD;
				end
				S_O_END: begin
					strobe_q <= 1'b1;
					obits_q  <= pend_v_q ? pend_q.bits : '0;
					omask_q  <= pend_v_q ? pend_q.mask : '0;
					oempty_q <= !pend_v_q;
					oovf_q   <= ovf_q;
					ofinal_q <= 1'b1;
					cnt_q    <= '0;
					ovf_q    <= 1'b0;
					state_q  <= S_LOAD;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign busy           = state_q != S_LOAD;
	assign strobe         = strobe_q;
	assign implicant_bits = obits_q;
	assign implicant_mask = omask_q;
	assign empty_res      = oempty_q;
	assign overflow       = oovf_q;
	assign final_res      = ofinal_q;

endmodule

@@ hw/rtl/qm_chk.sv @@
// Port checker for the logic minimizer and its bind to the top level.
module qm_chk (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    last,
	input logic                    strobe,
	input logic [qm_pkg::VARS-1:0] implicant_bits,
	input logic [qm_pkg::VARS-1:0] implicant_mask,
	input logic                    empty_res,
	input logic                    final_res
);

	// A transaction with last starts a job.
	a_job_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("job did not start after last item");

	// The final result ends the job; earlier results come while it runs.
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && final_res |-> !busy)
		else $error("block still busy with final result");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !final_res |-> busy)
		else $error("non-final result outside a job");

	// An empty function is one zero result that ends the job.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && empty_res |-> final_res && implicant_bits == '0 &&
		implicant_mask == '0)
		else $error("malformed empty result");

	// Eliminated variables carry zero literal bits.
	a_masked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (implicant_bits & implicant_mask) == '0)
		else $error("literal bit set under mask");

endmodule

bind logic_minimizer_qm qm_chk u_qm_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .last(last),
	.strobe(strobe), .implicant_bits(implicant_bits),
	.implicant_mask(implicant_mask), .empty_res(empty_res), .final_res(final_res)
);

@@ tb/qm_result_checker.sv @@
// Checker that predicts and compares the results of the logic minimizer.
`timescale 1ns / 100ps

module qm_result_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [qm_pkg::VARS-1:0] minterm,
	input  logic                    present,
	input  logic                    last,
	input  logic                    strobe,
	input  logic [qm_pkg::VARS-1:0] implicant_bits,
	input  logic [qm_pkg::VARS-1:0] implicant_mask,
	input  logic                    empty_res,
	input  logic                    overflow,
	input  logic                    final_res,
	output int                      fail_count,
	output int                      pending
);

	localparam int OUT_MAX = 64;

	typedef struct packed {
		logic [qm_pkg::VARS-1:0] bits;
		logic [qm_pkg::VARS-1:0] mask;
		logic                    empty;
		logic                    ovf;
		logic                    fin;
	} cover_item_t;

	cover_item_t cover_q[$];

	// Shadow of the block's job state.
	logic [qm_pkg::VARS-1:0] job_terms [qm_pkg::MT_DEPTH];
	int                      job_count;
	logic                    job_ovf;

	// Working tables of the minimizer.
	logic [qm_pkg::VARS-1:0] cur_b [qm_pkg::LVL_DEPTH];
	logic [qm_pkg::VARS-1:0] cur_m [qm_pkg::LVL_DEPTH];
	logic                    cur_g [qm_pkg::LVL_DEPTH];
	logic [qm_pkg::VARS-1:0] nxt_b [qm_pkg::LVL_DEPTH];
	logic [qm_pkg::VARS-1:0] nxt_m [qm_pkg::LVL_DEPTH];
	logic [qm_pkg::VARS-1:0] pr_b  [qm_pkg::PR_DEPTH];
	logic [qm_pkg::VARS-1:0] pr_m  [qm_pkg::PR_DEPTH];
	logic                    pr_sel[qm_pkg::PR_DEPTH];
	logic                    mt_cov[qm_pkg::MT_DEPTH];
	int                      pr_count;

	function automatic logic hits(logic [qm_pkg::VARS-1:0] b, logic [qm_pkg::VARS-1:0] m,
			logic [qm_pkg::VARS-1:0] v);
		return ((v & ~m) == (b & ~m));
	endfunction

	// Build the prime list by level-wise merging.
	function automatic void build_primes();
		int ncur, nnxt;
		logic [qm_pkg::VARS-1:0] d, b, m;
		logic found;
		ncur = 0;
		for (int i = 0; i < job_count && ncur < qm_pkg::LVL_DEPTH; i++) begin
			cur_b[ncur] = job_terms[i];
			cur_m[ncur] = '0;
			cur_g[ncur] = 1'b0;
			ncur++;
		end
		pr_count = 0;
		while (ncur > 0) begin
			nnxt = 0;
			for (int i = 0; i < ncur; i++) begin
				for (int j = i + 1; j < ncur; j++) begin
					if (cur_m[i] != cur_m[j])
						continue;
					d = cur_b[i] ^ cur_b[j];
					if (d == '0 || (d & (d - 1'b1)) != '0)
						continue;
					cur_g[i] = 1'b1;
					cur_g[j] = 1'b1;
					b = cur_b[i] & cur_b[j];
					m = cur_m[i] | d;
					found = 1'b0;
					for (int k = 0; k < nnxt; k++)
						if (nxt_b[k] == b && nxt_m[k] == m)
							found = 1'b1;
					if (!found && nnxt < qm_pkg::LVL_DEPTH) begin
						nxt_b[nnxt] = b;
						nxt_m[nnxt] = m;
						nnxt++;
					end
				end
			end
			// Terms that merged with nothing are primes.
			for (int i = 0; i < ncur; i++) begin
				if (cur_g[i])
					continue;
				found = 1'b0;
				for (int k = 0; k < pr_count; k++)
					if (pr_b[k] == cur_b[i] && pr_m[k] == cur_m[i])
						found = 1'b1;
				if (!found && pr_count < qm_pkg::PR_DEPTH) begin
					pr_b[pr_count] = cur_b[i];
					pr_m[pr_count] = cur_m[i];
					pr_count++;
				end
			end
			for (int i = 0; i < nnxt; i++) begin
				cur_b[i] = nxt_b[i];
				cur_m[i] = nxt_m[i];
				cur_g[i] = 1'b0;
			end
			ncur = nnxt;
		end
	endfunction

	function automatic void take_prime(int p);
		pr_sel[p] = 1'b1;
		for (int k = 0; k < job_count; k++)
			if (hits(pr_b[p], pr_m[p], job_terms[k]))
				mt_cov[k] = 1'b1;
	endfunction

	// Essential primes first, then greedy on uncovered minterms.
	function automatic void choose_cover();
		int n_hit, which, best, best_n, n;
		logic done;
		for (int i = 0; i < qm_pkg::PR_DEPTH; i++)
			pr_sel[i] = 1'b0;
		for (int i = 0; i < qm_pkg::MT_DEPTH; i++)
			mt_cov[i] = 1'b0;
		for (int i = 0; i < job_count; i++) begin
			n_hit = 0;
			which = 0;
			for (int j = 0; j < pr_count; j++)
				if (hits(pr_b[j], pr_m[j], job_terms[i])) begin
					n_hit++;
					which = j;
				end
			if (n_hit == 1)
				take_prime(which);
		end
		forever begin
			done = 1'b1;
			for (int i = 0; i < job_count; i++)
				if (!mt_cov[i])
					done = 1'b0;
			if (done)
				break;
			best = -1;
			best_n = 0;
			for (int i = 0; i < pr_count; i++) begin
				if (pr_sel[i])
					continue;
				n = 0;
				for (int j = 0; j < job_count; j++)
					if (!mt_cov[j] && hits(pr_b[i], pr_m[i], job_terms[j]))
						n++;
				if (n > best_n) begin
					best_n = n;
					best = i;
				end
			end
			if (best < 0)
				break;
			take_prime(best);
		end
	endfunction

	// Turn a finished job into its expected results.
	function automatic void predict_cover();
		int n;
		cover_item_t it;
		build_primes();
		choose_cover();
		n = 0;
		for (int i = 0; i < pr_count && n < OUT_MAX; i++) begin
			if (!pr_sel[i])
				continue;
			it = '{bits: pr_b[i], mask: pr_m[i], empty: 1'b0, ovf: job_ovf, fin: 1'b0};
			cover_q.push_back(it);
			n++;
		end
		if (n == 0)
			cover_q.push_back('{bits: '0, mask: '0, empty: 1'b1, ovf: job_ovf,
				fin: 1'b1});
		else
			cover_q[cover_q.size() - 1].fin = 1'b1;
		job_count = 0;
		job_ovf = 1'b0;
	endfunction

	// Track accepted transactions and check each result strobe.
	always @(posedge clk or negedge arst_n) begin
		cover_item_t want;
		if (!arst_n) begin
			job_count = 0;
			job_ovf = 1'b0;
			fail_count = 0;
			pending = cover_q.size();
		end else begin
			if (start && !busy) begin
				if (present) begin
					if (job_count < qm_pkg::MT_DEPTH) begin
						job_terms[job_count] = minterm;
						job_count++;
					end else
						job_ovf = 1'b1;
				end
				if (last)
					predict_cover();
			end
			if (strobe) begin
				if (cover_q.size() == 0) begin
					$display("%0t: expected no result, actual bits=%h mask=%h", $time,
						implicant_bits, implicant_mask);
					fail_count++;
				end else begin
					want = cover_q.pop_front();
					if (want !== {implicant_bits, implicant_mask, empty_res,
							overflow, final_res}) begin
						$display("%0t: expected bits=%h mask=%h empty=%b ovf=%b fin=%b",
							$time, want.bits, want.mask, want.empty, want.ovf, want.fin);
						$display("%0t: actual   bits=%h mask=%h empty=%b ovf=%b fin=%b",
							$time, implicant_bits, implicant_mask, empty_res, overflow,
							final_res);
						fail_count++;
					end
				end
			end
			pending = cover_q.size();
		end
	end

endmodule

@@ tb/logic_minimizer_qm_tb.sv @@
// Top of the logic minimizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module logic_minimizer_qm_tb;

	localparam int CYCLE_LIMIT = 6000000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [qm_pkg::VARS-1:0] minterm;
	logic                    present;
	logic                    last;
	logic                    strobe;
	logic [qm_pkg::VARS-1:0] implicant_bits;
	logic [qm_pkg::VARS-1:0] implicant_mask;
	logic                    empty_res;
	logic                    overflow;
	logic                    final_res;
	int                      fail_count;
	int                      pending;
	int                      cycle_count;
	int                      sent;
	logic                    calm;

	logic_minimizer_qm i_dut (.*);

	qm_result_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("logic_minimizer_qm: mismatch");
				$finish;
			end
		end
	end

	// Send one transaction and hold it until the block takes it.
	task automatic send_term(logic [qm_pkg::VARS-1:0] v, logic p, logic l);
		if (!calm && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		minterm <= v;
		present <= p;
		last <= l;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// A job of n minterms drawn around a base with a few free bits.
	task automatic send_job(int n, logic [qm_pkg::VARS-1:0] base,
			logic [qm_pkg::VARS-1:0] vary, logic gaps);
		for (int i = 0; i < n; i++) begin
			if (gaps && $urandom_range(0, 5) == 0)
				send_term(qm_pkg::VARS'($urandom), 1'b0, 1'b0);
			send_term(base ^ (qm_pkg::VARS'($urandom) & vary), 1'b1, i == n - 1);
		end
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		minterm = '0;
		present = 1'b0;
		last = 1'b0;
		sent = 0;
		calm = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, extremes, duplicates, a cube and a closing absent item.
		send_term(6'h2a, 1'b0, 1'b1);
		send_term(6'h00, 1'b1, 1'b1);
		send_term(6'h3f, 1'b1, 1'b1);
		send_term(6'h15, 1'b1, 1'b0);
		send_term(6'h15, 1'b1, 1'b1);
		send_term(6'h00, 1'b1, 1'b0);
		send_term(6'h3f, 1'b1, 1'b0);
		send_term(6'h3f, 1'b0, 1'b1);
		for (int i = 0; i < 8; i++)
			send_term(qm_pkg::VARS'(i << 3), 1'b1, i == 7);
		send_term(6'h01, 1'b1, 1'b0);
		send_term(6'h03, 1'b1, 1'b0);
		send_term(6'h07, 1'b1, 1'b0);
		send_term(6'h05, 1'b1, 1'b1);

		// Let every result drain before going on.
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		// Full and overflowing job: all 64 values plus two extra.
		for (int i = 0; i < 66; i++)
			send_term(qm_pkg::VARS'(i), 1'b1, i == 65);

		// Random jobs, mostly structured, some noise.
		while (sent < 280) begin
			if (sent > 240)
				calm = 1'b1;
			n = $urandom_range(1, 9);
			case ($urandom_range(0, 9))
				0: send_term(qm_pkg::VARS'($urandom), 1'($urandom_range(0, 1)), 1'b1);
				1: send_job(n, qm_pkg::VARS'($urandom), qm_pkg::VARS'($urandom), 1'b1);
				default: send_job(n, qm_pkg::VARS'($urandom),
					qm_pkg::VARS'($urandom) & qm_pkg::VARS'($urandom), !calm);
			endcase
		end

		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("logic_minimizer_qm: match");
		else
			$display("logic_minimizer_qm: mismatch");
		$finish;
	end

endmodule
